/* rtl/core/sat_pkg.sv */
// ----------------------------------------------------------------------------
// sat_pkg
// Shared constants, payload types and register indexes of the Sauvola
// adaptive threshold core.
// ----------------------------------------------------------------------------
package sat_pkg;

	localparam int MAX_WIDTH      = 1024;
	localparam int MAX_RADIUS     = 15;
	localparam int SQRT_FRAC_BITS = 8;

	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int WID_W     = COL_W + 1;
	localparam int RAD_W     = $clog2(MAX_RADIUS + 1);
	localparam int RING_ROWS = 2 * MAX_RADIUS + 2;
	localparam int SLOT_W    = $clog2(RING_ROWS);
	localparam int ADDR_W    = SLOT_W + COL_W;
	localparam int ROW_W     = 16;

	// window pixel count and sums
	localparam int WIN_SIDE = 2 * MAX_RADIUS + 1;
	localparam int CNT_W    = $clog2(WIN_SIDE * WIN_SIDE + 1);
	localparam int SIDE_W   = $clog2(WIN_SIDE + 1);
	localparam int SUM_W    = $clog2(WIN_SIDE * WIN_SIDE * 255 + 1);
	localparam int SQS_W    = $clog2(WIN_SIDE * WIN_SIDE * 65025 + 1);

	// divider and square root
	localparam int DIV_NUM_W = SQS_W;
	localparam int DIV_DEN_W = CNT_W;
	localparam int VAR_W     = 16;
	localparam int RAD_IN_W  = VAR_W + 2 * SQRT_FRAC_BITS;
	localparam int ROOT_W    = RAD_IN_W / 2;

	// threshold arithmetic
	localparam int THR_SHIFT = 21 + SQRT_FRAC_BITS;
	localparam int DIFF_W    = ROOT_W + 1;
	localparam int TERM_W    = DIFF_W + 17;
	localparam int ONEP_W    = TERM_W + 1;
	localparam int RHS_W     = ONEP_W + 9;

	localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] REG_RADIUS       = 2'd2;
	localparam logic [1:0] REG_K            = 2'd3;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	typedef struct packed {
		logic       command;
		logic [7:0] pixel_value;
	} in_word_t;

	typedef struct packed {
		logic [7:0] binary_value;
		logic       frame_last;
	} out_word_t;

endpackage

/* rtl/core/sat_row_mem.sv */
// ----------------------------------------------------------------------------
// sat_row_mem
// Ring of recent image rows: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sat_row_mem
	import sat_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [7:0]        rdata
);

	logic [7:0] mem [RING_ROWS * MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/sat_divider.sv */
// ----------------------------------------------------------------------------
// sat_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sat_divider
	import sat_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [DIV_DEN_W-1:0] den,
	output logic                 done,
	output logic [DIV_NUM_W-1:0] quot
);

	localparam int CW = $clog2(DIV_NUM_W);

	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   shifted;
	logic                 ge;

	assign shifted = {rem_q, quo_q[DIV_NUM_W-1]};
	assign ge      = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIV_NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? DIV_DEN_W'(shifted - {1'b0, den_q}) : shifted[DIV_DEN_W-1:0];
			quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

/* rtl/core/sat_isqrt.sv */
// ----------------------------------------------------------------------------
// sat_isqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module sat_isqrt
	import sat_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [RAD_IN_W-1:0] radicand,
	output logic                done,
	output logic [ROOT_W-1:0]   root
);

	localparam int CW = $clog2(ROOT_W);
	localparam int RW = ROOT_W + 3;

	logic [RAD_IN_W-1:0] rad_q;
	logic [RW-1:0]       rem_q;
	logic [ROOT_W-1:0]   root_q;
	logic [CW-1:0]       cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [RW-1:0]       r2;
	logic [RW-1:0]       trial;
	logic                ge;

	assign r2    = {rem_q[RW-3:0], rad_q[RAD_IN_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge    = r2 >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(ROOT_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_IN_W-3:0], 2'b00};
			rem_q  <= ge ? r2 - trial : r2;
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

/* rtl/core/sauvola_adaptive_threshold_core.sv */
// ----------------------------------------------------------------------------
// sauvola_adaptive_threshold_core
// Sauvola binarizer over a clipped square window, held in a row ring memory.
// ----------------------------------------------------------------------------
//  channel | signals                                   | dir | word
//  in      | in_valid, in_ready, in_data               | in  | in_word_t
//  out     | out_valid, out_ready, out_data            | out | out_word_t
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | in  | index + 16-bit data
//
//  An item that releases no result passes through the check state only. An
//  item that releases a result also scans its window, one read of the row
//  ring's single read port per window pixel, then runs the bit-serial divider
//  twice (mean, mean square) and the bit-serial square root once.
//  Reset clears control and position counters; the row ring is not cleared.
//  in_ready is high only between items; a finished result waits in the output
//  register while the next word is taken.
// ----------------------------------------------------------------------------
module sauvola_adaptive_threshold_core
	import sat_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_word_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_word_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CHECK = 4'd1;
	localparam logic [3:0] ST_SCAN  = 4'd2;
	localparam logic [3:0] ST_FLUSH = 4'd3;
	localparam logic [3:0] ST_DM0   = 4'd4;
	localparam logic [3:0] ST_DM1   = 4'd5;
	localparam logic [3:0] ST_DS0   = 4'd6;
	localparam logic [3:0] ST_DS1   = 4'd7;
	localparam logic [3:0] ST_SQ0   = 4'd8;
	localparam logic [3:0] ST_SQ1   = 4'd9;
	localparam logic [3:0] ST_MUL1  = 4'd10;
	localparam logic [3:0] ST_MUL2  = 4'd11;
	localparam logic [3:0] ST_EMIT  = 4'd12;

	logic [3:0] state_q;

	logic [WID_W-1:0] width_q;
	logic [ROW_W-1:0] height_q;
	logic [RAD_W-1:0] radius_q;
	logic [15:0]      k_q;

	logic [COL_W-1:0]  icol_q, ocol_q;
	logic [ROW_W-1:0]  irow_q, orow_q;
	logic [SLOT_W-1:0] in_slot_q, out_slot_q;

	logic in_acc, cfg_acc, emit;

	// effective geometry
	logic [WID_W-1:0]  w_eff, w_m1;
	logic [ROW_W-1:0]  h_eff, h_m1;
	logic [SLOT_W:0]   slots;
	logic [RAD_W-1:0]  rr, rc;
	logic              in_done;

	assign w_eff = (width_q == '0) ? WID_W'(1) :
	               (width_q > WID_W'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) : width_q;
	assign h_eff = (height_q == '0) ? ROW_W'(1) : height_q;
	assign w_m1  = w_eff - 1'b1;
	assign h_m1  = h_eff - 1'b1;
	assign slots = (SLOT_W+1)'({radius_q, 1'b0}) + (SLOT_W+1)'(2);
	assign rr    = (ROW_W'(radius_q) > h_m1) ? h_m1[RAD_W-1:0] : radius_q;
	assign rc    = (WID_W'(radius_q) > w_m1) ? w_m1[RAD_W-1:0] : radius_q;
	assign in_done = irow_q >= h_eff;

	function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s,
	                                               input logic [SLOT_W:0] n);
		logic [SLOT_W:0] t;
		t = (SLOT_W+1)'(s) + 1'b1;
		return (t == n) ? '0 : t[SLOT_W-1:0];
	endfunction

	assign in_acc  = in_valid && in_ready;
	assign cfg_acc = cfg_valid && cfg_ready;
	assign in_ready  = state_q == ST_IDLE;
	assign cfg_ready = 1'b1;

	// readiness of the next result: received position past q + lag
	logic [WID_W:0]   tcol_raw;
	logic             tcarry;
	logic [WID_W:0]   tcol;
	logic [ROW_W:0]   trow;
	logic             res_ready;

	assign tcol_raw = (WID_W+1)'(ocol_q) + (WID_W+1)'(rc);
	assign tcarry   = tcol_raw >= (WID_W+1)'(w_eff);
	assign tcol     = tcarry ? tcol_raw - (WID_W+1)'(w_eff) : tcol_raw;
	assign trow     = (ROW_W+1)'(orow_q) + (ROW_W+1)'(rr) + (ROW_W+1)'(tcarry);
	assign res_ready = (orow_q < h_eff) &&
	                   (in_done || ((ROW_W+1)'(irow_q) > trow) ||
	                    (((ROW_W+1)'(irow_q) == trow) && ((WID_W+1)'(icol_q) > tcol)));

	// window bounds
	logic [RAD_W-1:0]  dy, dx;
	logic [ROW_W:0]    y1_raw;
	logic [ROW_W-1:0]  y0, y1;
	logic [WID_W:0]    x1_raw;
	logic [COL_W-1:0]  x0, x1;
	logic [SIDE_W-1:0] rows, cols;
	logic [SLOT_W:0]   y0_slot;

	assign dy     = (orow_q > ROW_W'(radius_q)) ? radius_q : orow_q[RAD_W-1:0];
	assign dx     = (ocol_q > COL_W'(radius_q)) ? radius_q : ocol_q[RAD_W-1:0];
	assign y0     = orow_q - ROW_W'(dy);
	assign x0     = ocol_q - COL_W'(dx);
	assign y1_raw = (ROW_W+1)'(orow_q) + (ROW_W+1)'(radius_q);
	assign y1     = (y1_raw > (ROW_W+1)'(h_m1)) ? h_m1 : y1_raw[ROW_W-1:0];
	assign x1_raw = (WID_W+1)'(ocol_q) + (WID_W+1)'(radius_q);
	assign x1     = (x1_raw > (WID_W+1)'(w_m1)) ? w_m1[COL_W-1:0] : x1_raw[COL_W-1:0];
	assign rows   = SIDE_W'(y1 - y0) + 1'b1;
	assign cols   = SIDE_W'(x1 - x0) + 1'b1;
	assign y0_slot = ((SLOT_W+1)'(out_slot_q) >= (SLOT_W+1)'(dy)) ?
	                 (SLOT_W+1)'(out_slot_q) - (SLOT_W+1)'(dy) :
	                 (SLOT_W+1)'(out_slot_q) + slots - (SLOT_W+1)'(dy);

	// scan registers
	logic [COL_W-1:0]  x0_q, x1_q, sx_q;
	logic [SLOT_W-1:0] sslot_q;
	logic [SIDE_W-1:0] rows_left_q;
	logic [CNT_W-1:0]  n_q;
	logic              scan_last;
	logic              center;
	logic              issue_s1, center_s1;

	assign scan_last = (sx_q == x1_q) && (rows_left_q == SIDE_W'(1));
	assign center    = (sslot_q == out_slot_q) && (sx_q == ocol_q);

	logic [ADDR_W-1:0] raddr, waddr;
	logic [7:0]        rdata;
	logic              we;

	assign raddr = {sslot_q, sx_q};
	assign waddr = {in_slot_q, icol_q};
	assign we    = in_acc && (in_data.command == CMD_PIXEL) && !in_done;

	sat_row_mem u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (in_data.pixel_value),
		.raddr (raddr),
		.rdata (rdata)
	);

	// window sums
	logic [SUM_W-1:0] sum_q;
	logic [SQS_W-1:0] sqs_q;
	logic [7:0]       cur_q, mean_q;
	logic [VAR_W-1:0] var_q;

	// shared divider and root unit
	logic                 div_start, div_done;
	logic [DIV_NUM_W-1:0] div_num, div_quot;
	logic                 sq_start, sq_done;
	logic [ROOT_W-1:0]    sd;
	logic [VAR_W-1:0]     var_d;

	assign div_start = (state_q == ST_DM0) || (state_q == ST_DS0);
	assign div_num   = (state_q == ST_DM0) ? DIV_NUM_W'(sum_q) : DIV_NUM_W'(sqs_q);
	assign sq_start  = state_q == ST_SQ0;
	assign var_d     = div_quot[VAR_W-1:0] - (VAR_W'(mean_q) * VAR_W'(mean_q));

	sat_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (n_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	sat_isqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand ({var_q, {(2*SQRT_FRAC_BITS){1'b0}}}),
		.done     (sq_done),
		.root     (sd)
	);

	// threshold: pixel*2^THR_SHIFT < mean*(2^THR_SHIFT + k*(sd - 2^(f+7)))
	logic signed [DIFF_W-1:0] diff;
	logic signed [TERM_W-1:0] term_s1;
	logic signed [ONEP_W-1:0] onep;
	logic signed [RHS_W-1:0]  rhs_s2;
	logic signed [RHS_W-1:0]  lhs;
	logic [ROOT_W-1:0]        sd_q;

	assign diff = $signed({1'b0, sd_q}) - $signed(DIFF_W'(1) << (SQRT_FRAC_BITS + 7));
	assign onep = $signed(ONEP_W'(1) << THR_SHIFT) + ONEP_W'(term_s1);
	assign lhs  = $signed(RHS_W'({cur_q, {THR_SHIFT{1'b0}}}));

	// emit and output position advance
	logic              out_valid_q;
	out_word_t         out_q;
	logic [COL_W:0]    ocol_inc;
	logic              ocol_wrap;
	logic [ROW_W:0]    orow_inc;
	logic              frame_end;

	assign emit      = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign ocol_inc  = (COL_W+1)'(ocol_q) + 1'b1;
	assign ocol_wrap = ocol_inc >= (COL_W+1)'(w_eff);
	assign orow_inc  = (ROW_W+1)'(orow_q) + (ROW_W+1)'(ocol_wrap);
	assign frame_end = orow_inc >= (ROW_W+1)'(h_eff);

	// input position advance
	logic [COL_W:0] icol_inc;
	assign icol_inc = (COL_W+1)'(icol_q) + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WID_W'(640);
			height_q <= ROW_W'(480);
			radius_q <= RAD_W'(7);
			k_q      <= 16'd8192;
		end else if (cfg_acc) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  width_q  <= cfg_data[WID_W-1:0];
				REG_FRAME_HEIGHT: height_q <= cfg_data[ROW_W-1:0];
				REG_RADIUS:       radius_q <= cfg_data[RAD_W-1:0];
				REG_K:            k_q      <= cfg_data;
				default:          k_q      <= k_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			icol_q     <= '0;
			irow_q     <= '0;
			ocol_q     <= '0;
			orow_q     <= '0;
			in_slot_q  <= '0;
			out_slot_q <= '0;
		end else if (cfg_acc || (emit && frame_end)) begin
			icol_q     <= '0;
			irow_q     <= '0;
			ocol_q     <= '0;
			orow_q     <= '0;
			in_slot_q  <= '0;
			out_slot_q <= '0;
		end else if (we) begin
			if (icol_inc >= (COL_W+1)'(w_eff)) begin
				icol_q    <= '0;
				irow_q    <= irow_q + 1'b1;
				in_slot_q <= slot_next(in_slot_q, slots);
			end else begin
				icol_q <= icol_inc[COL_W-1:0];
			end
		end else if (emit) begin
			if (ocol_wrap) begin
				ocol_q     <= '0;
				orow_q     <= orow_inc[ROW_W-1:0];
				out_slot_q <= slot_next(out_slot_q, slots);
			end else begin
				ocol_q <= ocol_inc[COL_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			issue_s1  <= 1'b0;
			center_s1 <= 1'b0;
		end else begin
			issue_s1  <= state_q == ST_SCAN;
			center_s1 <= center;
			case (state_q)
				ST_IDLE:  if (in_acc) state_q <= ST_CHECK;
				ST_CHECK: state_q <= res_ready ? ST_SCAN : ST_IDLE;
				ST_SCAN:  if (scan_last) state_q <= ST_FLUSH;
				ST_FLUSH: state_q <= ST_DM0;
				ST_DM0:   state_q <= ST_DM1;
				ST_DM1:   if (div_done) state_q <= ST_DS0;
				ST_DS0:   state_q <= ST_DS1;
				ST_DS1:   if (div_done) state_q <= ST_SQ0;
				ST_SQ0:   state_q <= ST_SQ1;
				ST_SQ1:   if (sq_done) state_q <= ST_MUL1;
				ST_MUL1:  state_q <= ST_MUL2;
				ST_MUL2:  state_q <= ST_EMIT;
				ST_EMIT:  if (emit) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_CHECK) begin
			x0_q        <= x0;
			x1_q        <= x1;
			sx_q        <= x0;
			sslot_q     <= y0_slot[SLOT_W-1:0];
			rows_left_q <= rows;
			n_q         <= CNT_W'(rows) * CNT_W'(cols);
			sum_q       <= '0;
			sqs_q       <= '0;
		end else begin
			if (state_q == ST_SCAN) begin
				if (sx_q == x1_q) begin
					sx_q        <= x0_q;
					sslot_q     <= slot_next(sslot_q, slots);
					rows_left_q <= rows_left_q - 1'b1;
				end else begin
					sx_q <= sx_q + 1'b1;
				end
			end
			if (issue_s1) begin
				sum_q <= sum_q + SUM_W'(rdata);
				sqs_q <= sqs_q + SQS_W'(16'(rdata) * 16'(rdata));
			end
		end
		if (issue_s1 && center_s1) begin
			cur_q <= rdata;
		end
		if (state_q == ST_DM1 && div_done) begin
			mean_q <= div_quot[7:0];
		end
		if (state_q == ST_DS1 && div_done) begin
			var_q <= var_d;
		end
		if (state_q == ST_SQ1 && sq_done) begin
			sd_q <= sd;
		end
		if (state_q == ST_MUL1) begin
			term_s1 <= $signed({1'b0, k_q}) * diff;
		end
		if (state_q == ST_MUL2) begin
			rhs_s2 <= $signed({1'b0, mean_q}) * onep;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.binary_value <= (lhs < rhs_s2) ? 8'd0 : 8'd255;
			out_q.frame_last   <= frame_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// results never run ahead of received rows
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		orow_q <= irow_q)
		else $error("output row ahead of input row");

	// a scan read always lands in the cycle after it is issued
	a_scan_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |=> issue_s1)
		else $error("scan read lost");

	// a blocked result stays in the emit state
	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && out_valid_q && !out_ready) |=> (state_q == ST_EMIT))
		else $error("result dropped while output blocked");

	// no new word while a result is being computed
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |=> !in_ready || (state_q == ST_IDLE))
		else $error("input taken during window scan");

endmodule
